// ===== src/atqr_pkg.sv =====
// Shared constants and types for the atan2 rational-approximation pipeline.
package atqr_pkg;
	localparam int DEF_IN_WIDTH = 16;
	localparam int ANG_W = 16;
	localparam int NRM_W = 16;
	localparam int PRD_W = 2 * NRM_W;
	localparam int QUO_W = 13;
	localparam int DEN_W = PRD_W + 5;
	localparam int NUM_W = PRD_W + 5 + QUO_W + 1;
	localparam int ACC_W = 18;
	localparam logic signed [ACC_W-1:0] Q13_PI = 18'sd25736;
	localparam logic signed [ACC_W-1:0] Q13_HALF_PI = 18'sd12868;

	typedef struct packed {
		logic zx;
		logic yzero;
		logic lt;
		logic opp;
		logic xneg;
		logic yneg;
	} ctl_t;
endpackage

// ===== src/atqr_in_if.sv =====
// Input channel: one coordinate pair per transaction.
interface atqr_in_if #(parameter int IN_WIDTH = atqr_pkg::DEF_IN_WIDTH);
	logic valid;
	logic ready;
	logic signed [IN_WIDTH-1:0] y_coord;
	logic signed [IN_WIDTH-1:0] x_coord;
	modport source (output valid, output y_coord, output x_coord, input ready);
	modport sink (input valid, input y_coord, input x_coord, output ready);
endinterface

// ===== src/atqr_out_if.sv =====
// Output channel: one angle per transaction.
interface atqr_out_if;
	logic valid;
	logic ready;
	logic signed [atqr_pkg::ANG_W-1:0] angle;
	modport source (output valid, output angle, input ready);
	modport sink (input valid, input angle, output ready);
endinterface

// ===== src/atqr_prep.sv =====
// Magnitudes, quadrant flags and normalization of the operand pair to 16 bits.
module atqr_prep #(
	parameter int IN_WIDTH = atqr_pkg::DEF_IN_WIDTH
) (
	input  logic signed [IN_WIDTH-1:0]     y_coord,
	input  logic signed [IN_WIDTH-1:0]     x_coord,
	output atqr_pkg::ctl_t                 ctl,
	output logic [atqr_pkg::NRM_W-1:0]     big,
	output logic [atqr_pkg::NRM_W-1:0]     small_mag
);
	import atqr_pkg::*;

	localparam int MW = (IN_WIDTH > NRM_W) ? IN_WIDTH : NRM_W;
	localparam int SH_W = $clog2(MW + 1);

	logic [IN_WIDTH-1:0] ay, ax;
	logic [MW-1:0] big_w, small_w, big_sh, small_sh;
	logic [SH_W-1:0] sh;

	always_comb begin
		ay = y_coord[IN_WIDTH-1] ? IN_WIDTH'(-y_coord) : IN_WIDTH'(y_coord);
		ax = x_coord[IN_WIDTH-1] ? IN_WIDTH'(-x_coord) : IN_WIDTH'(x_coord);
		ctl.yneg = y_coord[IN_WIDTH-1];
		ctl.xneg = x_coord[IN_WIDTH-1];
		ctl.opp = y_coord[IN_WIDTH-1] ^ x_coord[IN_WIDTH-1];
		ctl.zx = (ax == '0);
		ctl.yzero = (ay == '0);
		ctl.lt = (ay < ax);
		big_w = ctl.lt ? MW'(ax) : MW'(ay);
		small_w = ctl.lt ? MW'(ay) : MW'(ax);
		// shift so the larger magnitude falls below 2^16
		sh = '0;
		for (int i = NRM_W; i < MW; i++) begin
			if (big_w[i]) sh = SH_W'(i - NRM_W + 1);
		end
		big_sh = big_w >> sh;
		small_sh = small_w >> sh;
		big = big_sh[NRM_W-1:0];
		small_mag = small_sh[NRM_W-1:0];
	end
endmodule

// ===== src/atqr_div_stage.sv =====
// One restoring-division step: produces one quotient bit per stage.
module atqr_div_stage #(
	parameter int SHIFT = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  atqr_pkg::ctl_t                ctl_in,
	input  logic [atqr_pkg::NUM_W-1:0]    rem_in,
	input  logic [atqr_pkg::DEN_W-1:0]    den_in,
	input  logic [atqr_pkg::QUO_W-1:0]    quo_in,
	output logic                          valid_out,
	output atqr_pkg::ctl_t                ctl_out,
	output logic [atqr_pkg::NUM_W-1:0]    rem_out,
	output logic [atqr_pkg::DEN_W-1:0]    den_out,
	output logic [atqr_pkg::QUO_W-1:0]    quo_out
);
	import atqr_pkg::*;

	logic [NUM_W-1:0] dsh;
	logic take;

	assign dsh = NUM_W'(den_in) << SHIFT;
	assign take = (rem_in >= dsh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_out <= ctl_in;
			den_out <= den_in;
			rem_out <= take ? rem_in - dsh : rem_in;
			quo_out <= quo_in | (take ? QUO_W'(1) << SHIFT : '0);
		end
	end
endmodule

// ===== src/atan2_quadrant_rational_approx.sv =====
// Top level: four-quadrant atan2 with the 0.28 rational approximation.
//
// Usage: coordinate pairs (y_coord, x_coord, signed Q1.(IN_WIDTH-1)) enter on
// the samples channel; angles (signed Q3.13 radians, saturated to +/-pi)
// leave on the angles channel, one per input, in order.
// Pipeline: s1 magnitudes, quadrant flags and normalization; s2 three 16x16
// products; s3 numerator and denominator; 13 restoring-division stages, one
// quotient bit each; one final stage that applies the quadrant and saturates.
// Throughput is one pair per cycle while the receiver keeps angles.ready
// high or the output register is empty; the division chain sets the depth.
// Reset clears all valid bits; the pipeline is empty afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and samples.ready drops; nothing is lost or repeated, and bubbles in
// the pipeline advance while the output register is empty.
module atan2_quadrant_rational_approx #(
	parameter int IN_WIDTH = atqr_pkg::DEF_IN_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	atqr_in_if.sink      samples,
	atqr_out_if.source   angles
);
	import atqr_pkg::*;

	localparam int NDIV = QUO_W;

	logic en;
	ctl_t ctl_c;
	logic [NRM_W-1:0] big_c, small_c;

	logic v_s1, v_s2, v_s3, v_out;
	ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [NRM_W-1:0] big_s1, small_s1;
	logic [PRD_W-1:0] pbs_s2, pbb_s2, pss_s2;
	logic [NUM_W-1:0] num_s3;
	logic [DEN_W-1:0] den_s3;

	logic             dv   [NDIV+1];
	ctl_t             dctl [NDIV+1];
	logic [NUM_W-1:0] drem [NDIV+1];
	logic [DEN_W-1:0] dden [NDIV+1];
	logic [QUO_W-1:0] dquo [NDIV+1];

	logic signed [ACC_W-1:0] qs, a_c;
	logic [ANG_W-1:0] angle_s;

	assign en = !v_out || angles.ready;
	assign samples.ready = en;

	atqr_prep #(.IN_WIDTH(IN_WIDTH)) u_prep (
		.y_coord   (samples.y_coord),
		.x_coord   (samples.x_coord),
		.ctl       (ctl_c),
		.big       (big_c),
		.small_mag (small_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_out <= 1'b0;
		end else if (en) begin
			v_s1 <= samples.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_out <= dv[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_c;
			big_s1 <= big_c;
			small_s1 <= small_c;
			ctl_s2 <= ctl_s1;
			pbs_s2 <= PRD_W'(big_s1) * PRD_W'(small_s1);
			pbb_s2 <= PRD_W'(big_s1) * PRD_W'(big_s1);
			pss_s2 <= PRD_W'(small_s1) * PRD_W'(small_s1);
			ctl_s3 <= ctl_s2;
			// 25*p*8192; the half-divisor rounding term is added at the divider input
			num_s3 <= ((NUM_W'(pbs_s2) << 4) + (NUM_W'(pbs_s2) << 3) + NUM_W'(pbs_s2))
				<< QUO_W;
			den_s3 <= (DEN_W'(pbb_s2) << 4) + (DEN_W'(pbb_s2) << 3) + DEN_W'(pbb_s2)
				+ (DEN_W'(pss_s2) << 3) - DEN_W'(pss_s2);
			angle_s <= a_c[ANG_W-1:0];
		end
	end

	assign dv[0] = v_s3;
	assign dctl[0] = ctl_s3;
	assign drem[0] = num_s3 + NUM_W'(den_s3 >> 1);
	assign dden[0] = den_s3;
	assign dquo[0] = '0;

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		atqr_div_stage #(.SHIFT(NDIV - 1 - g)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (dv[g]),
			.ctl_in    (dctl[g]),
			.rem_in    (drem[g]),
			.den_in    (dden[g]),
			.quo_in    (dquo[g]),
			.valid_out (dv[g+1]),
			.ctl_out   (dctl[g+1]),
			.rem_out   (drem[g+1]),
			.den_out   (dden[g+1]),
			.quo_out   (dquo[g+1])
		);
	end

	always_comb begin
		qs = dctl[NDIV].opp ? -ACC_W'(dquo[NDIV]) : ACC_W'(dquo[NDIV]);
		if (dctl[NDIV].zx) begin
			if (dctl[NDIV].yzero) a_c = '0;
			else a_c = dctl[NDIV].yneg ? -Q13_HALF_PI : Q13_HALF_PI;
		end else if (dctl[NDIV].lt) begin
			a_c = qs;
			if (dctl[NDIV].xneg) a_c = dctl[NDIV].yneg ? qs - Q13_PI : qs + Q13_PI;
		end else begin
			a_c = Q13_HALF_PI - qs;
			if (dctl[NDIV].yneg) a_c = a_c - Q13_PI;
		end
		if (a_c > Q13_PI) a_c = Q13_PI;
		if (a_c < -Q13_PI) a_c = -Q13_PI;
	end

	assign angles.valid = v_out;
	assign angles.angle = $signed(angle_s);

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid |-> ($signed(angles.angle) <= 16'sd25736 &&
			$signed(angles.angle) >= -16'sd25736))
		else $error("angle out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(angles.valid && !angles.ready) |-> !samples.ready)
		else $error("input taken while output stalled");
endmodule
